/* hw/rtl/svpg_pkg.sv */
// Shared types, codes and constants of the servo pulse generator.
`timescale 1ns / 1ps

package svpg_pkg;

    localparam int CHANNELS   = 8;
    localparam int CH_W       = $clog2(CHANNELS);
    localparam int OP_W       = 2;
    localparam int VAL_W      = 12;
    localparam int FRAME_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // angle operand and scaled product of the angle map
    localparam int ANGLE_W    = 8;
    localparam int PROD_W     = ANGLE_W + VAL_W;

    // floor(x / 180) = floor((x >> 2) / 45) = ((x >> 2) * RECIP_MULT) >> RECIP_SHIFT,
    // exact for x below 2^20
    localparam int RECIP_SHIFT          = 24;
    localparam int RECIP_W              = 19;
    localparam logic [RECIP_W-1:0] RECIP_MULT = 19'd372828;
    localparam int SCALED_W             = (PROD_W - 2) + RECIP_W;

    // item opcodes
    localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OP_W-1:0] OP_WIDTH = 2'd1;
    localparam logic [OP_W-1:0] OP_ANGLE = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_TICKS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_WIDTH_US   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_WIDTH_US   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_ENABLE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RUN_ENABLE     = 3'd4;

    localparam logic [FRAME_W-1:0] FRAME_TICKS_RST = 16'd40000;
    localparam logic [VAL_W-1:0]   MIN_WIDTH_RST   = 12'd544;
    localparam logic [VAL_W-1:0]   MAX_WIDTH_RST   = 12'd2400;
    localparam logic [VAL_W-1:0]   PULSE_WIDTH_RST = 12'd1500;
    localparam logic [VAL_W-1:0]   ANGLE_MAX       = 12'd180;

    typedef struct packed {
        logic [FRAME_W-1:0]  frame_ticks;
        logic [VAL_W-1:0]    min_width_us;
        logic [VAL_W-1:0]    max_width_us;
        logic [CHANNELS-1:0] channel_enable;
        logic                run_enable;
    } svpg_cfg_t;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [CH_W-1:0]  channel;
        logic [VAL_W-1:0] value;
    } svpg_item_t;

    typedef struct packed {
        svpg_item_t       item;
        logic             angle_ok;
        logic [VAL_W-1:0] offset_us;
    } svpg_job_t;

endpackage

/* hw/rtl/svpg_angle_map.sv */
// Input register and two-stage angle-to-width scaling pipeline.
`timescale 1ns / 1ps

module svpg_angle_map import svpg_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  svpg_cfg_t  cfg,
    input  logic       s_valid,
    output logic       s_ready,
    input  svpg_item_t s_item,
    output logic       m_valid,
    input  logic       m_ready,
    output svpg_job_t  m_job
);

    logic             in_valid_reg;
    svpg_item_t       in_item_reg;

    logic             prod_valid_reg;
    svpg_item_t       prod_item_reg;
    logic             prod_ok_reg;
    logic [PROD_W-1:0] prod_reg;

    logic             quo_valid_reg;
    svpg_job_t        quo_job_reg;

    logic             in_ready, prod_ready, quo_ready;
    logic [VAL_W-1:0] diff_us;
    logic             angle_ok;
    logic [PROD_W-1:0] prod_next;
    logic [SCALED_W-1:0] scaled;

    assign quo_ready  = !quo_valid_reg || m_ready;
    assign prod_ready = !prod_valid_reg || quo_ready;
    assign in_ready   = !in_valid_reg || prod_ready;
    assign s_ready    = in_ready;

    // span of the width range; only meaningful when the limits are ordered
    assign diff_us   = cfg.max_width_us - cfg.min_width_us;
    assign angle_ok  = (in_item_reg.value <= ANGLE_MAX) &&
                       (cfg.min_width_us <= cfg.max_width_us);
    assign prod_next = PROD_W'(in_item_reg.value[ANGLE_W-1:0]) * PROD_W'(diff_us);

    assign scaled = SCALED_W'(prod_reg[PROD_W-1:2]) * SCALED_W'(RECIP_MULT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
            quo_valid_reg  <= 1'b0;
        end else begin
            if (in_ready) begin
                in_valid_reg <= s_valid;
            end
            if (prod_ready) begin
                prod_valid_reg <= in_valid_reg;
            end
            if (quo_ready) begin
                quo_valid_reg <= prod_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && s_valid) begin
            in_item_reg <= s_item;
        end
        if (prod_ready && in_valid_reg) begin
            prod_item_reg <= in_item_reg;
            prod_ok_reg   <= angle_ok;
            prod_reg      <= prod_next;
        end
        if (quo_ready && prod_valid_reg) begin
            quo_job_reg.item      <= prod_item_reg;
            quo_job_reg.angle_ok  <= prod_ok_reg;
            quo_job_reg.offset_us <= scaled[RECIP_SHIFT +: VAL_W];
        end
    end

    assign m_valid = quo_valid_reg;
    assign m_job   = quo_job_reg;

    // a held stage never drops its word
    a_prod_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (prod_valid_reg && !quo_ready) |=> prod_valid_reg)
        else $error("product stage lost a word");

    a_quo_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (quo_valid_reg && !m_ready) |=> quo_valid_reg)
        else $error("quotient stage lost a word");

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !prod_ready) |=> in_valid_reg)
        else $error("input stage lost a word");

endmodule

/* hw/rtl/svpg_core.sv */
// Frame counter, pulse width store, per-channel compares and result register.
`timescale 1ns / 1ps

module svpg_core import svpg_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  svpg_cfg_t           cfg,
    input  logic                s_valid,
    output logic                s_ready,
    input  svpg_job_t           s_job,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [CHANNELS-1:0] m_pin_levels,
    output logic                m_accepted,
    output logic                m_frame_start
);

    logic [VAL_W-1:0]    width_reg [CHANNELS];
    logic [VAL_W-1:0]    width_next [CHANNELS];
    logic [FRAME_W-1:0]  counter_reg, counter_next;
    logic [CHANNELS-1:0] levels_reg, levels_next;
    logic                res_valid_reg;
    logic                accepted_reg, accepted_next;
    logic                frame_start_reg, frame_start_next;

    logic                fire;
    logic [FRAME_W-1:0]  pos;
    logic [FRAME_W:0]    pos_inc;
    logic [FRAME_W-1:0]  counter_tick;
    logic [CHANNELS-1:0] levels_tick;
    logic [VAL_W:0]      us_full;
    logic                ch_ok, range_ok, write_ok;

    assign s_ready = !res_valid_reg || m_ready;
    assign fire    = s_valid && s_ready;

    // stopped: counter reads as zero
    assign pos          = cfg.run_enable ? counter_reg : '0;
    assign pos_inc      = (FRAME_W + 1)'(pos) + (FRAME_W + 1)'(1);
    assign counter_tick = (pos_inc >= (FRAME_W + 1)'(cfg.frame_ticks)) ? '0 :
                          pos_inc[FRAME_W-1:0];

    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            levels_tick[c] = cfg.channel_enable[c] &&
                ((FRAME_W + 1)'(pos) < (FRAME_W + 1)'({width_reg[c], 1'b0}));
        end
    end

    assign us_full  = (s_job.item.op == OP_ANGLE) ?
                      ((VAL_W + 1)'(cfg.min_width_us) + (VAL_W + 1)'(s_job.offset_us)) :
                      (VAL_W + 1)'(s_job.item.value);
    assign ch_ok    = (32'(s_job.item.channel) < CHANNELS) &&
                      cfg.channel_enable[s_job.item.channel];
    assign range_ok = (us_full >= (VAL_W + 1)'(cfg.min_width_us)) &&
                      (us_full <= (VAL_W + 1)'(cfg.max_width_us));

    always_comb begin
        width_next       = width_reg;
        counter_next     = pos;
        levels_next      = cfg.run_enable ? levels_reg : '0;
        accepted_next    = 1'b0;
        frame_start_next = 1'b0;
        write_ok         = 1'b0;
        case (s_job.item.op)
            OP_TICK: begin
                accepted_next = 1'b1;
                if (cfg.run_enable) begin
                    frame_start_next = (pos == '0);
                    levels_next      = levels_tick;
                    counter_next     = counter_tick;
                end
            end
            OP_WIDTH: begin
                write_ok = ch_ok && range_ok;
            end
            OP_ANGLE: begin
                write_ok = s_job.angle_ok && ch_ok && range_ok;
            end
            default: begin
            end
        endcase
        if (write_ok) begin
            accepted_next                  = 1'b1;
            width_next[s_job.item.channel] = us_full[VAL_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
            counter_reg   <= '0;
            levels_reg    <= '0;
            for (int c = 0; c < CHANNELS; c++) begin
                width_reg[c] <= PULSE_WIDTH_RST;
            end
        end else begin
            if (s_ready) begin
                res_valid_reg <= s_valid;
            end
            if (fire) begin
                counter_reg <= counter_next;
                levels_reg  <= levels_next;
                width_reg   <= width_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            accepted_reg    <= accepted_next;
            frame_start_reg <= frame_start_next;
        end
    end

    // levels change only with a new word, so they double as the result field
    assign m_valid       = res_valid_reg;
    assign m_pin_levels  = levels_reg;
    assign m_accepted    = accepted_reg;
    assign m_frame_start = frame_start_reg;

    a_fs_accepted: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid_reg && frame_start_reg) |-> accepted_reg)
        else $error("frame start on a rejected word");

    a_tick_accepted: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && s_job.item.op == OP_TICK) |=> (res_valid_reg && accepted_reg))
        else $error("tick not reported as accepted");

    a_write_no_fs: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && s_job.item.op != OP_TICK) |=> !frame_start_reg)
        else $error("frame start on a write");

    a_write_levels: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && s_job.item.op != OP_TICK && cfg.run_enable) |=> $stable(levels_reg))
        else $error("write changed pin levels");

endmodule

/* hw/rtl/multi_channel_servo_pulse_generator_unit.sv */
// Top level: configuration registers and the servo pulse pipeline.
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+------------------
//  input    | s_op, s_channel, s_value                | s_valid / s_ready
//  result   | m_pin_levels, m_accepted, m_frame_start | m_valid / m_ready
//  config   | cfg_addr, cfg_wr_data                   | cfg_wr_en
//
// One word per cycle while results are taken; a word passes through the input register, the angle
// product, the divide-by-180 product and the result register, in that order.
// Widths, frame counter and pin levels change in the last stage only, in order.
// aresetn is synchronous, active low; it loads the default registers and widths.
// A stalled result backs up the stages; an empty stage still fills while the next waits.
`timescale 1ns / 1ps

module multi_channel_servo_pulse_generator_unit import svpg_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [OP_W-1:0]       s_op,
    input  logic [CH_W-1:0]       s_channel,
    input  logic [VAL_W-1:0]      s_value,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [CHANNELS-1:0]   m_pin_levels,
    output logic                  m_accepted,
    output logic                  m_frame_start
);

    svpg_cfg_t  cfg_reg;
    svpg_item_t s_item;
    svpg_job_t  job;
    logic       job_valid, job_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_ticks    <= FRAME_TICKS_RST;
            cfg_reg.min_width_us   <= MIN_WIDTH_RST;
            cfg_reg.max_width_us   <= MAX_WIDTH_RST;
            cfg_reg.channel_enable <= '0;
            cfg_reg.run_enable     <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_FRAME_TICKS:    cfg_reg.frame_ticks    <= cfg_wr_data[FRAME_W-1:0];
                REG_MIN_WIDTH_US:   cfg_reg.min_width_us   <= cfg_wr_data[VAL_W-1:0];
                REG_MAX_WIDTH_US:   cfg_reg.max_width_us   <= cfg_wr_data[VAL_W-1:0];
                REG_CHANNEL_ENABLE: cfg_reg.channel_enable <= cfg_wr_data[CHANNELS-1:0];
                REG_RUN_ENABLE:     cfg_reg.run_enable     <= cfg_wr_data[0];
                default: begin
                end
            endcase
        end
    end

    assign s_item.op      = s_op;
    assign s_item.channel = s_channel;
    assign s_item.value   = s_value;

    svpg_angle_map u_angle_map (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (job_valid),
        .m_ready (job_ready),
        .m_job   (job)
    );

    svpg_core u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .s_valid       (job_valid),
        .s_ready       (job_ready),
        .s_job         (job),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pin_levels  (m_pin_levels),
        .m_accepted    (m_accepted),
        .m_frame_start (m_frame_start)
    );

endmodule

/* verif/multi_channel_servo_pulse_generator_unit_tb.sv */
// Self-checking testbench for the multi-channel servo pulse generator.
`timescale 1ns / 1ps

module multi_channel_servo_pulse_generator_unit_tb;
    import svpg_pkg::*;

    localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

    localparam int PHASES       = 10;
    localparam int PHASE_WORDS  = 40;
    localparam int MAX_WAIT     = 18;
    localparam int DRAIN_CYCLES = 8;
    localparam int END_WAIT     = 2000;
    localparam int RUN_LIMIT    = 200000;

    typedef struct packed {
        logic [CHANNELS-1:0] pin_levels;
        logic                accepted;
        logic                frame_start;
    } pulse_result_t;

    typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  addr;
        logic [OP_W-1:0]       op;
        logic [CH_W-1:0]       channel;
        logic [CFG_DATA_W-1:0] data;    // word value or register data
        logic                  typed;   // want holds the result to expect
        pulse_result_t         want;
    } plan_row_t;

    localparam int PLAN_ROWS = 38;
    localparam plan_row_t PLAN_TABLE [PLAN_ROWS] = '{
        // stopped, nothing enabled
        '{ROW_WORD, '0, OP_TICK,     3'd0, 16'd0,    1'b1, '{8'h00, 1'b1, 1'b0}},
        '{ROW_WORD, '0, OP_WIDTH,    3'd0, 16'd1500, 1'b1, '{8'h00, 1'b0, 1'b0}},
        '{ROW_WORD, '0, OP_RESERVED, 3'd7, 16'd4095, 1'b1, '{8'h00, 1'b0, 1'b0}},
        '{ROW_REG,  REG_CHANNEL_ENABLE, '0, '0, 16'h00FF, 1'b0, '0},
        // limits at reset, writes still land while stopped
        '{ROW_WORD, '0, OP_WIDTH,    3'd1, 16'd543,  1'b1, '{8'h00, 1'b0, 1'b0}},
        '{ROW_WORD, '0, OP_WIDTH,    3'd2, 16'd544,  1'b1, '{8'h00, 1'b1, 1'b0}},
        '{ROW_WORD, '0, OP_ANGLE,    3'd3, 16'd180,  1'b1, '{8'h00, 1'b1, 1'b0}},
        '{ROW_WORD, '0, OP_ANGLE,    3'd4, 16'd181,  1'b1, '{8'h00, 1'b0, 1'b0}},
        '{ROW_REG,  REG_FRAME_TICKS,  '0, '0, 16'd6,    1'b0, '0},
        '{ROW_REG,  REG_MIN_WIDTH_US, '0, '0, 16'd0,    1'b0, '0},
        '{ROW_REG,  REG_MAX_WIDTH_US, '0, '0, 16'd4095, 1'b0, '0},
        '{ROW_REG,  REG_RUN_ENABLE,   '0, '0, 16'd1,    1'b0, '0},
        // full-range limits, zero and max widths
        '{ROW_WORD, '0, OP_WIDTH,    3'd0, 16'd0,    1'b1, '{8'h00, 1'b1, 1'b0}},
        '{ROW_WORD, '0, OP_WIDTH,    3'd7, 16'd4095, 1'b1, '{8'h00, 1'b1, 1'b0}},
        '{ROW_WORD, '0, OP_ANGLE,    3'd1, 16'd0,    1'b1, '{8'h00, 1'b1, 1'b0}},
        '{ROW_WORD, '0, OP_ANGLE,    3'd5, 16'd4095, 1'b1, '{8'h00, 1'b0, 1'b0}},
        '{ROW_WORD, '0, OP_WIDTH,    3'd6, 16'd2,    1'b1, '{8'h00, 1'b1, 1'b0}},
        '{ROW_WORD, '0, OP_ANGLE,    3'd5, 16'd1,    1'b0, '0},
        // one frame of six ticks and the wrap
        '{ROW_WORD, '0, OP_TICK,     3'd0, 16'd0,    1'b0, '0},
        '{ROW_WORD, '0, OP_TICK,     3'd0, 16'd0,    1'b0, '0},
        '{ROW_WORD, '0, OP_TICK,     3'd0, 16'd0,    1'b0, '0},
        '{ROW_WORD, '0, OP_TICK,     3'd0, 16'd0,    1'b0, '0},
        '{ROW_WORD, '0, OP_TICK,     3'd0, 16'd0,    1'b0, '0},
        '{ROW_WORD, '0, OP_TICK,     3'd0, 16'd0,    1'b0, '0},
        '{ROW_WORD, '0, OP_TICK,     3'd0, 16'd0,    1'b0, '0},
        // min above max rejects every write
        '{ROW_REG,  REG_MIN_WIDTH_US, '0, '0, 16'd3000, 1'b0, '0},
        '{ROW_REG,  REG_MAX_WIDTH_US, '0, '0, 16'd100,  1'b0, '0},
        '{ROW_WORD, '0, OP_WIDTH,    3'd2, 16'd2000, 1'b0, '0},
        '{ROW_WORD, '0, OP_ANGLE,    3'd2, 16'd90,   1'b0, '0},
        // zero frame length, half the channels dropped
        '{ROW_REG,  REG_FRAME_TICKS,    '0, '0, 16'd0,    1'b0, '0},
        '{ROW_REG,  REG_MIN_WIDTH_US,   '0, '0, 16'd544,  1'b0, '0},
        '{ROW_REG,  REG_MAX_WIDTH_US,   '0, '0, 16'd2400, 1'b0, '0},
        '{ROW_REG,  REG_CHANNEL_ENABLE, '0, '0, 16'h0055, 1'b0, '0},
        '{ROW_WORD, '0, OP_TICK,     3'd0, 16'd0,    1'b0, '0},
        '{ROW_WORD, '0, OP_TICK,     3'd0, 16'd0,    1'b0, '0},
        '{ROW_REG,  REG_FRAME_TICKS,    '0, '0, 16'hFFFF, 1'b0, '0},
        '{ROW_REG,  REG_RUN_ENABLE,     '0, '0, 16'd0,    1'b0, '0},
        '{ROW_WORD, '0, OP_TICK,     3'd0, 16'd0,    1'b1, '{8'h00, 1'b1, 1'b0}}
    };

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wr_data;
    logic                  s_valid;
    logic                  s_ready;
    logic [OP_W-1:0]       s_op;
    logic [CH_W-1:0]       s_channel;
    logic [VAL_W-1:0]      s_value;
    logic                  m_valid;
    logic                  m_ready;
    logic [CHANNELS-1:0]   m_pin_levels;
    logic                  m_accepted;
    logic                  m_frame_start;

    // pulse generator state as the block should hold it
    svpg_cfg_t             cur_cfg;
    logic [VAL_W-1:0]      stored_us [CHANNELS];
    logic [FRAME_W-1:0]    frame_pos;
    logic [CHANNELS-1:0]   pin_state;

    pulse_result_t         expected_pulses [$];

    bit          tx_calm;
    bit          rx_calm;
    int unsigned mismatches;
    int unsigned words_sent;
    int unsigned results_checked;
    int unsigned writes_applied;
    int unsigned writes_rejected;
    int unsigned frames_begun;
    int unsigned settings_used;
    int unsigned cycle_count = 0;

    multi_channel_servo_pulse_generator_unit u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_channel     (s_channel),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pin_levels  (m_pin_levels),
        .m_accepted    (m_accepted),
        .m_frame_start (m_frame_start)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     expected_pulses.size());
            $display("multi_channel_servo_pulse_generator_unit_tb NOT OK");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("[%0t] mismatch: %s got 0x%0h expected 0x%0h", $time, what, got, want);
        mismatches++;
    endtask

    function automatic bit store_width(input int unsigned ch, input int unsigned us);
        if (!cur_cfg.channel_enable[ch])
            return 1'b0;
        if (us < cur_cfg.min_width_us || us > cur_cfg.max_width_us)
            return 1'b0;
        stored_us[ch] = us[VAL_W-1:0];
        return 1'b1;
    endfunction

    function automatic pulse_result_t predict_pulse(input logic [OP_W-1:0] op,
                                                    input logic [CH_W-1:0] ch,
                                                    input logic [VAL_W-1:0] val);
        pulse_result_t r;
        int unsigned   pos;
        int unsigned   lo;
        int unsigned   hi;
        r = '0;
        if (!cur_cfg.run_enable) begin
            frame_pos = '0;
            pin_state = '0;
        end
        case (op)
            OP_TICK: begin
                r.accepted = 1'b1;
                if (cur_cfg.run_enable) begin
                    pos = 32'(frame_pos);
                    r.frame_start = (pos == 0);
                    for (int c = 0; c < CHANNELS; c++)
                        pin_state[c] = cur_cfg.channel_enable[c] &&
                                       (pos < 2 * 32'(stored_us[c]));
                    pos = pos + 1;
                    frame_pos = (pos >= 32'(cur_cfg.frame_ticks)) ? '0 : pos[FRAME_W-1:0];
                end
            end
            OP_WIDTH: r.accepted = store_width(32'(ch), 32'(val));
            OP_ANGLE: begin
                lo = 32'(cur_cfg.min_width_us);
                hi = 32'(cur_cfg.max_width_us);
                // linear map of 0..180 degrees, truncating
                if (val <= ANGLE_MAX && lo <= hi)
                    r.accepted = store_width(32'(ch),
                                             lo + (32'(val) * (hi - lo)) / 32'(ANGLE_MAX));
            end
            default: ;
        endcase
        r.pin_levels = pin_state;
        return r;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= data;
        case (idx)
            REG_FRAME_TICKS:    cur_cfg.frame_ticks    = data[FRAME_W-1:0];
            REG_MIN_WIDTH_US:   cur_cfg.min_width_us   = data[VAL_W-1:0];
            REG_MAX_WIDTH_US:   cur_cfg.max_width_us   = data[VAL_W-1:0];
            REG_CHANNEL_ENABLE: cur_cfg.channel_enable = data[CHANNELS-1:0];
            REG_RUN_ENABLE:     cur_cfg.run_enable     = data[0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    // hold the sender until every outstanding result is back
    task automatic settle();
        s_valid <= 1'b0;
        while (expected_pulses.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic send_word(input logic [OP_W-1:0] op, input logic [CH_W-1:0] ch,
                             input logic [VAL_W-1:0] val, input bit typed,
                             input pulse_result_t want);
        int            gap;
        pulse_result_t predicted;
        gap = tx_calm ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_op      <= op;
        s_channel <= ch;
        s_value   <= val;
        s_valid   <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        predicted = predict_pulse(op, ch, val);
        expected_pulses.push_back(typed ? want : predicted);
        words_sent++;
        if (op == OP_WIDTH || op == OP_ANGLE) begin
            if (predicted.accepted)
                writes_applied++;
            else
                writes_rejected++;
        end
        if (predicted.frame_start)
            frames_begun++;
        @(negedge aclk);
    endtask

    // result sink: random stall before taking each word unless rx_calm is set
    initial begin : result_sink
        int stall;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            stall = rx_calm ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    always @(posedge aclk) begin : result_check
        pulse_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_pulses.size() == 0) begin
                report_mismatch("result with nothing pending", m_pin_levels, 0);
            end else begin
                want = expected_pulses.pop_front();
                results_checked++;
                if (m_pin_levels !== want.pin_levels)
                    report_mismatch("pin_levels", m_pin_levels, want.pin_levels);
                if (m_accepted !== want.accepted)
                    report_mismatch("accepted", m_accepted, want.accepted);
                if (m_frame_start !== want.frame_start)
                    report_mismatch("frame_start", m_frame_start, want.frame_start);
            end
        end
    end

    initial begin : stimulus
        plan_row_t        row;
        svpg_cfg_t        setting;
        logic [OP_W-1:0]  op;
        logic [CH_W-1:0]  ch;
        logic [VAL_W-1:0] val;
        int               pick;
        int               lo;
        int               hi;
        int               waited;

        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_addr    = '0;
        cfg_wr_data = '0;
        s_valid     = 1'b0;
        s_op        = OP_TICK;
        s_channel   = '0;
        s_value     = '0;

        cur_cfg.frame_ticks    = FRAME_TICKS_RST;
        cur_cfg.min_width_us   = MIN_WIDTH_RST;
        cur_cfg.max_width_us   = MAX_WIDTH_RST;
        cur_cfg.channel_enable = '0;
        cur_cfg.run_enable     = 1'b0;
        foreach (stored_us[c])
            stored_us[c] = PULSE_WIDTH_RST;
        frame_pos = '0;
        pin_state = '0;

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int i = 0; i < PLAN_ROWS; i++) begin
            row = PLAN_TABLE[i];
            if (row.kind == ROW_REG) begin
                settle();
                write_reg(row.addr, row.data);
            end else begin
                send_word(row.op, row.channel, row.data[VAL_W-1:0], row.typed, row.want);
            end
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            // short frames and narrow limits so pulse ends can fall inside a frame
            setting.frame_ticks    = FRAME_W'($urandom_range(1, 40));
            setting.min_width_us   = VAL_W'($urandom_range(0, 12));
            setting.max_width_us   = setting.min_width_us + VAL_W'($urandom_range(0, 20));
            setting.channel_enable = CHANNELS'($urandom_range(0, 255));
            setting.run_enable     = ($urandom_range(0, 7) != 0);
            case (phase)
                0: begin
                    setting.frame_ticks    = 16'hFFFF;
                    setting.min_width_us   = '0;
                    setting.max_width_us   = 12'hFFF;
                    setting.channel_enable = '1;
                    setting.run_enable     = 1'b1;
                end
                1: setting.frame_ticks = 16'd1;
                2: setting.frame_ticks = 16'd0;
                3: begin
                    setting.min_width_us = 12'd30;
                    setting.max_width_us = 12'd3;
                end
                4: setting.run_enable = 1'b0;
                5: begin
                    setting.channel_enable = '1;
                    setting.max_width_us   = setting.min_width_us;
                end
                default: ;
            endcase

            settle();
            write_reg(REG_FRAME_TICKS, CFG_DATA_W'(setting.frame_ticks));
            write_reg(REG_MIN_WIDTH_US, CFG_DATA_W'(setting.min_width_us));
            write_reg(REG_MAX_WIDTH_US, CFG_DATA_W'(setting.max_width_us));
            write_reg(REG_CHANNEL_ENABLE, CFG_DATA_W'(setting.channel_enable));
            write_reg(REG_RUN_ENABLE, CFG_DATA_W'(setting.run_enable));
            settings_used++;
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);

            for (int n = 0; n < PHASE_WORDS; n++) begin
                if (n == PHASE_WORDS / 2 && phase % 3 == 0)
                    settle();
                pick = $urandom_range(0, 99);
                ch   = CH_W'($urandom_range(0, CHANNELS - 1));
                val  = VAL_W'($urandom_range(0, 4095));
                if (pick < 55) begin
                    op = OP_TICK;
                end else if (pick < 75) begin
                    op = OP_WIDTH;
                    // mostly near the accepted window, edges included
                    if ($urandom_range(0, 9) < 7) begin
                        lo  = int'(cur_cfg.min_width_us) - 5;
                        hi  = int'(cur_cfg.max_width_us) + 5;
                        lo  = (lo < 0) ? 0 : lo;
                        hi  = (hi > 4095) ? 4095 : hi;
                        val = VAL_W'($urandom_range(lo, hi));
                    end
                end else if (pick < 93) begin
                    op = OP_ANGLE;
                    if ($urandom_range(0, 3) != 0)
                        val = VAL_W'($urandom_range(0, ANGLE_MAX));
                end else begin
                    op = OP_RESERVED;
                end
                send_word(op, ch, val, 1'b0, '0);
            end
        end

        s_valid <= 1'b0;
        waited = 0;
        while (expected_pulses.size() != 0 && waited < END_WAIT) begin
            @(negedge aclk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (expected_pulses.size() != 0)
            report_mismatch("results never returned", expected_pulses.size(), 0);

        $display("sent %0d words under %0d random settings plus the directed table",
                 words_sent, settings_used);
        $display("checked %0d results: %0d writes applied, %0d rejected, %0d frame starts",
                 results_checked, writes_applied, writes_rejected, frames_begun);
        if (mismatches == 0) begin
            $display("multi_channel_servo_pulse_generator_unit_tb OK");
        end else begin
            $display("multi_channel_servo_pulse_generator_unit_tb NOT OK");
        end
        $finish;
    end

endmodule

/* multi_channel_servo_pulse_generator_unit.f */
hw/rtl/svpg_pkg.sv
hw/rtl/svpg_angle_map.sv
hw/rtl/svpg_core.sv
hw/rtl/multi_channel_servo_pulse_generator_unit.sv
verif/multi_channel_servo_pulse_generator_unit_tb.sv
